[rtl/core/gce_pkg.sv]
`timescale 1ns / 1ps
// Package with shared types and codes for the graph coloring enumerator.
package gce_pkg;
  localparam int unsigned OpW = 2;
  localparam int unsigned NodeW = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ColorOutW = 64;
  localparam int unsigned CountW = 63;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [OpW-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OpW-1:0] OP_RESTART = 2'd1;
  localparam logic [OpW-1:0] OP_NEXT = 2'd2;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  localparam logic [StatusW-1:0] ST_EDGE_OK = 3'd0;
  localparam logic [StatusW-1:0] ST_EDGE_REJ = 3'd1;
  localparam logic [StatusW-1:0] ST_COLORING = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_MORE = 3'd3;
  localparam logic [StatusW-1:0] ST_RESTARTED = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_COLOR_COUNT = 1'd1;

  typedef struct packed {
    logic [OpW-1:0] operation;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ColorOutW-1:0] coloring;
    logic [CountW-1:0] found_count;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDataW-1:0] data;
  } cfg_t;
endpackage

[rtl/core/gce_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload.
interface gce_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/gce_datapath.sv]
`timescale 1ns / 1ps
// Datapath: adjacency matrix, color registers, search cursor and the legality checks.
module gce_datapath #(
  parameter int unsigned MaxNodes = 16,
  parameter int unsigned ColorBits = 4,
  parameter int unsigned IdxW = $clog2(MaxNodes),
  parameter int unsigned DepW = $clog2(MaxNodes + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_clear_i,
  input  logic cmd_add_edge_i,
  input  logic [IdxW-1:0] edge_a_i,
  input  logic [IdxW-1:0] edge_b_i,
  input  logic cmd_begin_i,
  input  logic cmd_resume_i,
  input  logic cmd_try_i,
  input  logic cmd_fwd_i,
  input  logic cmd_count_i,
  input  logic [DepW-1:0] n_i,
  input  logic [ColorBits-1:0] m_i,
  output logic done_o,
  output logic found_o,
  output logic [gce_pkg::ColorOutW-1:0] coloring_o,
  output logic [gce_pkg::CountW-1:0] total_o
);
  import gce_pkg::*;

  logic [MaxNodes-1:0] adj_q [MaxNodes];
  logic [ColorBits-1:0] col_q [MaxNodes];
  logic [ColorBits-1:0] col_d [MaxNodes];
  logic [DepW-1:0] dep_q, dep_d;
  logic [ColorBits:0] try_q, try_d;
  logic [IdxW-1:0] fv_q, fv_d;
  logic in_fwd_q, in_fwd_d;
  logic done_q, done_d, found_q, found_d;
  logic [CountW-1:0] total_q;
  logic [MaxNodes-1:0] act;
  logic [IdxW-1:0] d_idx;
  logic [MaxNodes-1:0] nb_d, nb_v;
  logic [(1 << ColorBits)-1:0] used_v;
  logic [ColorBits-1:0] tc;
  logic tc_ok, v_has;
  logic [DepW:0] nlim;

  always_comb begin
    for (int i = 0; i < MaxNodes; i++) act[i] = (DepW'(i) < n_i);
  end

  assign d_idx = dep_q[IdxW-1:0];
  assign tc = try_q[ColorBits-1:0];
  assign nb_d = adj_q[d_idx] & act & ~(MaxNodes'(1) << d_idx);
  assign nb_v = adj_q[fv_q] & act & ~(MaxNodes'(1) << fv_q);

  always_comb begin
    tc_ok = 1'b1;
    for (int w = 0; w < MaxNodes; w++) begin
      if (nb_d[w] && col_q[w] == tc) tc_ok = 1'b0;
    end
    used_v = '0;
    for (int w = 0; w < MaxNodes; w++) begin
      if (nb_v[w] && col_q[w] != '0) used_v[col_q[w]] = 1'b1;
    end
    v_has = 1'b0;
    for (int c = 1; c < (1 << ColorBits); c++) begin
      if (ColorBits'(c) <= m_i && !used_v[c]) v_has = 1'b1;
    end
  end

  assign nlim = {1'b0, n_i};

  always_comb begin
    col_d = col_q;
    dep_d = dep_q;
    try_d = try_q;
    fv_d = fv_q;
    in_fwd_d = in_fwd_q;
    done_d = 1'b0;
    found_d = found_q;
    if (cmd_clear_i) begin
      for (int i = 0; i < MaxNodes; i++) col_d[i] = '0;
      dep_d = '0;
    end else if (cmd_begin_i) begin
      for (int i = 0; i < MaxNodes; i++) col_d[i] = '0;
      dep_d = '0;
      try_d = (ColorBits+1)'(1);
      in_fwd_d = 1'b0;
    end else if (cmd_resume_i) begin
      if (dep_q > n_i) dep_d = n_i;
    end else if (cmd_try_i) begin
      if (dep_q == '0) begin
        done_d = 1'b1;
        found_d = 1'b0;
      end else begin
        dep_d = dep_q - 1'b1;
        try_d = {1'b0, col_q[dep_q[IdxW-1:0] - 1'b1]} + 1'b1;
        col_d[dep_q[IdxW-1:0] - 1'b1] = '0;
      end
    end else if (cmd_fwd_i) begin
      if (in_fwd_q) begin
        if (nb_d[fv_q] && col_q[fv_q] == '0 && !v_has) begin
          col_d[d_idx] = '0;
          try_d = try_q + 1'b1;
          in_fwd_d = 1'b0;
        end else if (fv_q == IdxW'(MaxNodes - 1)) begin
          in_fwd_d = 1'b0;
          dep_d = dep_q + 1'b1;
          try_d = (ColorBits+1)'(1);
        end else begin
          fv_d = fv_q + 1'b1;
        end
      end else if ({1'b0, dep_q} >= nlim) begin
        done_d = 1'b1;
        found_d = 1'b1;
      end else if (try_q > {1'b0, m_i}) begin
        if (dep_q == '0) begin
          done_d = 1'b1;
          found_d = 1'b0;
        end else begin
          dep_d = dep_q - 1'b1;
          try_d = {1'b0, col_q[d_idx - 1'b1]} + 1'b1;
          col_d[d_idx - 1'b1] = '0;
        end
      end else if (!tc_ok) begin
        try_d = try_q + 1'b1;
      end else begin
        col_d[d_idx] = tc;
        in_fwd_d = 1'b1;
        fv_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxNodes; i++) begin
        adj_q[i] <= '0;
        col_q[i] <= '0;
      end
      dep_q <= '0;
      try_q <= '0;
      fv_q <= '0;
      in_fwd_q <= 1'b0;
      done_q <= 1'b0;
      found_q <= 1'b0;
      total_q <= '0;
    end else begin
      col_q <= col_d;
      dep_q <= dep_d;
      try_q <= try_d;
      fv_q <= fv_d;
      in_fwd_q <= in_fwd_d;
      done_q <= done_d;
      found_q <= found_d;
      if (cmd_add_edge_i && edge_a_i != edge_b_i) begin
        adj_q[edge_a_i][edge_b_i] <= 1'b1;
        adj_q[edge_b_i][edge_a_i] <= 1'b1;
      end
      if (cmd_clear_i) total_q <= '0;
      else if (cmd_count_i) total_q <= total_q + 1'b1;
    end
  end

  always_comb begin
    coloring_o = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      if (i * ColorBits < ColorOutW && act[i]) begin
        coloring_o = coloring_o | (ColorOutW'(col_q[i]) << (i * ColorBits));
      end
    end
  end

  assign done_o = done_q;
  assign found_o = found_q;
  assign total_o = total_q;
endmodule

[rtl/core/gce_ctrl.sv]
`timescale 1ns / 1ps
// Controller: decodes requests, sequences the search and holds the result register.
module gce_ctrl #(
  parameter int unsigned MaxNodes = 16,
  parameter int unsigned ColorBits = 4,
  parameter int unsigned IdxW = $clog2(MaxNodes),
  parameter int unsigned DepW = $clog2(MaxNodes + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  gce_pkg::req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output gce_pkg::rsp_t out_rsp_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  gce_pkg::cfg_t cfg_i,
  output logic cmd_clear_o,
  output logic cmd_add_edge_o,
  output logic [IdxW-1:0] edge_a_o,
  output logic [IdxW-1:0] edge_b_o,
  output logic cmd_begin_o,
  output logic cmd_resume_o,
  output logic cmd_try_o,
  output logic cmd_fwd_o,
  output logic cmd_count_o,
  output logic [DepW-1:0] n_o,
  output logic [ColorBits-1:0] m_o,
  input  logic done_i,
  input  logic found_i,
  input  logic [gce_pkg::ColorOutW-1:0] coloring_i,
  input  logic [gce_pkg::CountW-1:0] total_i
);
  import gce_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESUME = 3'd1;
  localparam logic [2:0] S_TRY = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0] state_q, state_d;
  logic [4:0] ncfg_q, ncfg_d;
  logic [3:0] mcfg_q, mcfg_d;
  logic started_q, started_d, exhausted_q, exhausted_d;
  logic out_valid_q, out_valid_d;
  rsp_t rsp_q, rsp_d;
  logic accept, out_free;
  logic a_ok, b_ok;

  assign n_o = ({1'b0, ncfg_q} > 6'(MaxNodes)) ? DepW'(MaxNodes) : DepW'(ncfg_q);
  assign m_o = ({2'b0, mcfg_q} > 6'((1 << ColorBits) - 1)) ? ColorBits'((1 << ColorBits) - 1)
             : ColorBits'(mcfg_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign a_ok = {1'b0, in_req_i.node_a} < (6)'(n_o);
  assign b_ok = {1'b0, in_req_i.node_b} < (6)'(n_o);
  assign edge_a_o = in_req_i.node_a[IdxW-1:0];
  assign edge_b_o = in_req_i.node_b[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    cmd_clear_o = 1'b0;
    cmd_add_edge_o = 1'b0;
    cmd_begin_o = 1'b0;
    cmd_resume_o = 1'b0;
    cmd_try_o = 1'b0;
    cmd_fwd_o = 1'b0;
    cmd_count_o = 1'b0;
    if (cfg_valid_i) cmd_clear_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_req_i.operation)
            OP_ADD_EDGE: cmd_add_edge_o = a_ok && b_ok;
            OP_RESTART: cmd_clear_o = 1'b1;
            OP_NEXT: begin
              if (exhausted_q) state_d = S_IDLE;
              else if (!started_q) begin
                cmd_begin_o = 1'b1;
                state_d = S_SEARCH;
              end else begin
                cmd_resume_o = 1'b1;
                state_d = S_RESUME;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RESUME: begin
        cmd_try_o = 1'b1;
        state_d = S_TRY;
      end
      S_TRY: begin
        if (done_i) state_d = S_FINISH;
        else begin
          cmd_fwd_o = 1'b1;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (done_i) state_d = S_FINISH;
        else cmd_fwd_o = 1'b1;
      end
      S_FINISH: begin
        if (found_i) cmd_count_o = 1'b1;
        state_d = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ncfg_d = ncfg_q;
    mcfg_d = mcfg_q;
    started_d = started_q;
    exhausted_d = exhausted_q;
    out_valid_d = out_valid_q;
    rsp_d = rsp_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_i.index)
        REG_NODE_COUNT: ncfg_d = cfg_i.data;
        REG_COLOR_COUNT: mcfg_d = cfg_i.data[3:0];
        default: ncfg_d = ncfg_q;
      endcase
      started_d = 1'b0;
      exhausted_d = 1'b0;
    end
    if (accept) begin
      rsp_d.coloring = '0;
      rsp_d.found_count = total_i;
      case (in_req_i.operation)
        OP_ADD_EDGE: begin
          rsp_d.status = (a_ok && b_ok) ? ST_EDGE_OK : ST_EDGE_REJ;
          out_valid_d = 1'b1;
        end
        OP_RESTART: begin
          started_d = 1'b0;
          exhausted_d = 1'b0;
          rsp_d.status = ST_RESTARTED;
          rsp_d.found_count = '0;
          out_valid_d = 1'b1;
        end
        OP_NEXT: begin
          started_d = 1'b1;
          if (exhausted_q) begin
            rsp_d.status = ST_NO_MORE;
            out_valid_d = 1'b1;
          end
        end
        default: begin
          rsp_d.status = ST_EDGE_REJ;
          out_valid_d = 1'b1;
        end
      endcase
    end
    if (state_q == S_FINISH && !found_i) exhausted_d = 1'b1;
    if (state_q == S_REPORT && out_free) begin
      out_valid_d = 1'b1;
      if (found_i) begin
        rsp_d.status = ST_COLORING;
        rsp_d.coloring = coloring_i;
      end else begin
        rsp_d.status = ST_NO_MORE;
        rsp_d.coloring = '0;
      end
      rsp_d.found_count = total_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ncfg_q <= 5'd16;
      mcfg_q <= 4'd3;
      started_q <= 1'b0;
      exhausted_q <= 1'b0;
      out_valid_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      state_q <= state_d;
      ncfg_q <= ncfg_d;
      mcfg_q <= mcfg_d;
      started_q <= started_d;
      exhausted_q <= exhausted_d;
      out_valid_q <= out_valid_d;
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = rsp_q;
endmodule

[rtl/core/graph_coloring_enumerator.sv]
`timescale 1ns / 1ps
// Top level of the graph coloring enumerator.
// The block takes requests on in_ch: add an undirected edge, restart the
// enumeration, or ask for the next proper coloring. Every request gives
// exactly one response on out_ch with a status, the packed coloring and the
// number of colorings found since the last restart or configuration write.
// Edge, restart and invalid requests answer in the cycle after the transfer.
// A next request runs a depth-first search with forward checking: one color
// trial or one neighbor check per cycle, and each placed color is followed
// by neighbor checks over the nodes in order. The search steps through the
// controller states RESUME and TRY (when resuming), SEARCH, FINISH and
// REPORT, and the response is registered once it ends; one request is in
// flight at a time.
// Configuration writes on cfg_ch set node_count (index 0) and color_count
// (index 1) and end any enumeration in progress; write them while idle.
// Reset clears the graph, the colors and the count, and sets 16 nodes and
// 3 colors. While the receiver stalls, the response register holds and no
// new request is taken.
module graph_coloring_enumerator #(
  parameter int unsigned MaxNodes = 16,
  parameter int unsigned ColorBits = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  gce_if.sink in_ch,
  gce_if.source out_ch,
  gce_if.sink cfg_ch
);
  import gce_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxNodes);
  localparam int unsigned DepW = $clog2(MaxNodes + 1);

  logic cmd_clear, cmd_add_edge, cmd_begin, cmd_resume, cmd_try, cmd_fwd, cmd_count;
  logic [IdxW-1:0] edge_a, edge_b;
  logic [DepW-1:0] n_eff;
  logic [ColorBits-1:0] m_eff;
  logic done, found;
  logic [ColorOutW-1:0] coloring;
  logic [CountW-1:0] total;

  gce_ctrl #(.MaxNodes(MaxNodes), .ColorBits(ColorBits)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_req_i(in_ch.payload),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_rsp_o(out_ch.payload),
    .cfg_valid_i(cfg_ch.valid), .cfg_ready_o(cfg_ch.ready), .cfg_i(cfg_ch.payload),
    .cmd_clear_o(cmd_clear), .cmd_add_edge_o(cmd_add_edge),
    .edge_a_o(edge_a), .edge_b_o(edge_b),
    .cmd_begin_o(cmd_begin), .cmd_resume_o(cmd_resume), .cmd_try_o(cmd_try),
    .cmd_fwd_o(cmd_fwd), .cmd_count_o(cmd_count), .n_o(n_eff), .m_o(m_eff),
    .done_i(done), .found_i(found), .coloring_i(coloring), .total_i(total)
  );

  gce_datapath #(.MaxNodes(MaxNodes), .ColorBits(ColorBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_clear_i(cmd_clear), .cmd_add_edge_i(cmd_add_edge),
    .edge_a_i(edge_a), .edge_b_i(edge_b),
    .cmd_begin_i(cmd_begin), .cmd_resume_i(cmd_resume), .cmd_try_i(cmd_try),
    .cmd_fwd_i(cmd_fwd), .cmd_count_i(cmd_count), .n_i(n_eff), .m_i(m_eff),
    .done_o(done), .found_o(found), .coloring_o(coloring), .total_o(total)
  );
endmodule

[rtl/core/gce_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the graph coloring enumerator, bound to the top level.
module gce_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input gce_pkg::rsp_t out_rsp
);
  import gce_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp)) else $error("response dropped");
  a_no_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("request taken while stalled");
  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_rsp.status != ST_COLORING |-> out_rsp.coloring == '0)
    else $error("coloring not zero");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_rsp.status <= ST_RESTARTED) else $error("bad status");
endmodule

bind graph_coloring_enumerator gce_checker u_gce_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rsp(out_ch.payload)
);
